/* src/nnsc_pkg.sv */
// shared types and constants of the nearest neighbor shape classifier
package nnsc_pkg;

   localparam int LABEL_BITS  = 8;
   localparam int WEIGHT_BITS = 16;
   localparam int PORT_FEAT_BITS = 16;
   localparam int DIST_BITS   = 50;
   localparam int NUM_FEATS   = 4;
   localparam int STATUS_BITS = 2;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [STATUS_BITS-1:0] STATUS_MATCH   = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_DATA = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_STORED  = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd3;

   localparam logic FUNC_STORE    = 1'b0;
   localparam logic FUNC_CLASSIFY = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WEIGHT_FILL      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WEIGHT_ASPECT    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WEIGHT_HU_FIRST  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WEIGHT_HU_SECOND = 2'd3;

   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

/* src/nnsc_cell.sv */
// one storage cell of the training vector ring
module nnsc_cell #(
   parameter int ENTRY_BITS = 72
) (
   input  logic                   clock,
   input  nnsc_pkg::cell_ctrl_type ctrl,
   input  logic [ENTRY_BITS-1:0]  load_data,
   input  logic [ENTRY_BITS-1:0]  neighbor_data,
   output logic [ENTRY_BITS-1:0]  entry_data
);
   import nnsc_pkg::*;

   logic [ENTRY_BITS-1:0] entry_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         entry_ff <= load_data;
      end else if (ctrl.shift) begin
         entry_ff <= neighbor_data;
      end
   end

   assign entry_data = entry_ff;

endmodule

/* src/nnsc_dist.sv */
// pipelined weighted squared distance between the query and one entry
module nnsc_dist #(
   parameter int FB = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  logic [nnsc_pkg::LABEL_BITS-1:0]               in_label,
   input  logic [nnsc_pkg::NUM_FEATS-1:0][FB-1:0]        in_feats,
   input  logic [nnsc_pkg::NUM_FEATS-1:0][FB-1:0]        query,
   input  logic [nnsc_pkg::NUM_FEATS-1:0][nnsc_pkg::WEIGHT_BITS-1:0] weights,
   output logic                                          out_valid,
   output logic [nnsc_pkg::LABEL_BITS-1:0]               out_label,
   output logic [nnsc_pkg::DIST_BITS-1:0]                out_dist,
   output logic                                          busy
);
   import nnsc_pkg::*;

   localparam int PB = 32;
   localparam int SB = 64;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic [LABEL_BITS-1:0] lab1_ff, lab2_ff, lab3_ff, lab4_ff;
   logic [NUM_FEATS-1:0][FB-1:0] d_ff;
   logic [NUM_FEATS-1:0][PB-1:0] p_ff;
   logic [NUM_FEATS-1:0][SB-1:0] s_ff;
   logic [DIST_BITS-1:0] sum_ff;
   logic [DIST_BITS+1:0] sum_in;
   logic [NUM_FEATS-1:0][DIST_BITS-1:0] sat;

   always_comb begin
      sum_in = '0;
      for (int j = 0; j < NUM_FEATS; j++) begin
         sat[j] = (s_ff[j][SB-1:DIST_BITS] != '0) ? DIST_MAX : s_ff[j][DIST_BITS-1:0];
         sum_in = sum_in + (DIST_BITS+2)'(sat[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      lab1_ff <= in_label;
      lab2_ff <= lab1_ff;
      lab3_ff <= lab2_ff;
      lab4_ff <= lab3_ff;
      for (int j = 0; j < NUM_FEATS; j++) begin
         d_ff[j] <= (query[j] >= in_feats[j]) ? (query[j] - in_feats[j])
                                               : (in_feats[j] - query[j]);
         p_ff[j] <= PB'(d_ff[j]) * PB'(weights[j]);
         s_ff[j] <= SB'(p_ff[j]) * SB'(p_ff[j]);
      end
      sum_ff <= (sum_in[DIST_BITS+1:DIST_BITS] != 2'b00) ? DIST_MAX
                                                         : sum_in[DIST_BITS-1:0];
   end

   assign out_valid = v4_ff;
   assign out_label = lab4_ff;
   assign out_dist  = sum_ff;
   assign busy      = v1_ff | v2_ff | v3_ff | v4_ff;

endmodule

/* src/nearest_neighbor_shape_classifier.sv */
// top level of the nearest neighbor shape classifier
//
// req channel: one item per transfer. func store appends a labelled vector
// to the table (status stored, or status full when the table holds
// MAX_ENTRIES vectors); func classify returns the label and squared
// weighted distance of the nearest stored vector (status match), or status
// no data on an empty table. every item gives exactly one rsp transfer.
// csr port: four 16-bit weights, written only while the block is idle:
// a rule for the user that the block does not enforce. store and
// empty-table items answer in the cycle after the transfer. a classify
// rotates the ring of MAX_ENTRIES cells once past a single 4-stage
// distance pipeline. one item is in work at a time; a new item is taken
// only while the block is idle and the rsp register is free or being
// drained. reset empties the table and loads the default weights; no
// clearing pass. a stalled rsp holds its result and no new item is taken.
module nearest_neighbor_shape_classifier #(
   parameter int MAX_ENTRIES  = 256,
   parameter int FEATURE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_func,
   input  logic [nnsc_pkg::LABEL_BITS-1:0]        req_class_label,
   input  logic [nnsc_pkg::PORT_FEAT_BITS-1:0]    req_fill_fraction,
   input  logic [nnsc_pkg::PORT_FEAT_BITS-1:0]    req_aspect_ratio,
   input  logic [nnsc_pkg::PORT_FEAT_BITS-1:0]    req_hu_first,
   input  logic [nnsc_pkg::PORT_FEAT_BITS-1:0]    req_hu_second,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [nnsc_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [nnsc_pkg::LABEL_BITS-1:0]        rsp_best_label,
   output logic [nnsc_pkg::DIST_BITS-1:0]         rsp_best_distance,
   input  logic                                   csr_write_enable,
   input  logic [nnsc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [nnsc_pkg::WEIGHT_BITS-1:0]       csr_write_data
);
   import nnsc_pkg::*;

   localparam int FB = FEATURE_BITS;
   localparam int ENTRY_BITS = LABEL_BITS + NUM_FEATS * FB;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam logic [IW-1:0] LAST_STEP = IW'(MAX_ENTRIES - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type state_ff;
   logic [CW-1:0] count_ff;
   logic [IW-1:0] step_ff;
   logic [NUM_FEATS-1:0][WEIGHT_BITS-1:0] weight_ff;
   logic [NUM_FEATS-1:0][FB-1:0] query_ff;
   logic [DIST_BITS-1:0] best_ff;
   logic [LABEL_BITS-1:0] best_label_ff;
   logic have_ff;
   logic rsp_valid_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [LABEL_BITS-1:0] rsp_label_ff;
   logic [DIST_BITS-1:0] rsp_dist_ff;

   logic req_xfer, out_free, scanning;
   logic [NUM_FEATS-1:0][FB-1:0] req_feats;
   logic [ENTRY_BITS-1:0] load_data;
   logic [MAX_ENTRIES-1:0][ENTRY_BITS-1:0] cell_data;
   logic [ENTRY_BITS-1:0] head;
   logic dist_valid, dist_busy;
   logic [LABEL_BITS-1:0] dist_label;
   logic [DIST_BITS-1:0] dist_sum;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_xfer  = req_valid && req_ready;
   assign scanning  = (state_ff == ST_SCAN);

   assign req_feats[0] = req_fill_fraction[FB-1:0];
   assign req_feats[1] = req_aspect_ratio[FB-1:0];
   assign req_feats[2] = req_hu_first[FB-1:0];
   assign req_feats[3] = req_hu_second[FB-1:0];
   assign load_data = {req_class_label, req_feats};

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      cell_ctrl_type ctrl;
      assign ctrl.shift = scanning;
      assign ctrl.load  = req_xfer && (req_func == FUNC_STORE) && (count_ff == CW'(i));
      nnsc_cell #(
         .ENTRY_BITS(ENTRY_BITS)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .load_data    (load_data),
         .neighbor_data(cell_data[(i + 1) % MAX_ENTRIES]),
         .entry_data   (cell_data[i])
      );
   end

   assign head = cell_data[0];

   nnsc_dist #(
      .FB(FB)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (scanning && (CW'(step_ff) < count_ff)),
      .in_label (head[ENTRY_BITS-1 -: LABEL_BITS]),
      .in_feats (head[NUM_FEATS*FB-1:0]),
      .query    (query_ff),
      .weights  (weight_ff),
      .out_valid(dist_valid),
      .out_label(dist_label),
      .out_dist (dist_sum),
      .busy     (dist_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         weight_ff[0] <= WEIGHT_BITS'(5);
         weight_ff[1] <= WEIGHT_BITS'(256);
         weight_ff[2] <= WEIGHT_BITS'(10);
         weight_ff[3] <= WEIGHT_BITS'(100);
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_WEIGHT_FILL:      weight_ff[0] <= csr_write_data;
               CSR_WEIGHT_ASPECT:    weight_ff[1] <= csr_write_data;
               CSR_WEIGHT_HU_FIRST:  weight_ff[2] <= csr_write_data;
               CSR_WEIGHT_HU_SECOND: weight_ff[3] <= csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (dist_valid && (!have_ff || dist_sum < best_ff)) begin
            best_ff       <= dist_sum;
            best_label_ff <= dist_label;
            have_ff       <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  rsp_label_ff <= '0;
                  rsp_dist_ff  <= '0;
                  if (req_func == FUNC_STORE) begin
                     rsp_valid_ff <= 1'b1;
                     if (count_ff == FULL_COUNT) begin
                        rsp_status_ff <= STATUS_FULL;
                     end else begin
                        rsp_status_ff <= STATUS_STORED;
                        count_ff      <= count_ff + 1'b1;
                     end
                  end else if (count_ff == '0) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= STATUS_NO_DATA;
                  end else begin
                     query_ff <= req_feats;
                     have_ff  <= 1'b0;
                     step_ff  <= '0;
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!dist_busy && out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= STATUS_MATCH;
                  rsp_label_ff  <= best_label_ff;
                  rsp_dist_ff   <= best_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_best_label    = rsp_label_ff;
   assign rsp_best_distance = rsp_dist_ff;

endmodule

/* test/tb_nearest_neighbor_shape_classifier.sv */
// testbench for the nearest neighbor shape classifier: random and directed checks
`timescale 1ns / 1ps

module tb_nearest_neighbor_shape_classifier;
   import nnsc_pkg::*;

   localparam int TABLE_DEPTH = 256;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic                      func;
      logic [LABEL_BITS-1:0]     label;
      logic [PORT_FEAT_BITS-1:0] feat [NUM_FEATS];
   } shape_item_type;

   typedef struct {
      logic [STATUS_BITS-1:0] status;
      logic [LABEL_BITS-1:0]  label;
      logic [DIST_BITS-1:0]   distance;
   } match_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_func;
   logic [LABEL_BITS-1:0]     req_class_label;
   logic [PORT_FEAT_BITS-1:0] req_fill_fraction;
   logic [PORT_FEAT_BITS-1:0] req_aspect_ratio;
   logic [PORT_FEAT_BITS-1:0] req_hu_first;
   logic [PORT_FEAT_BITS-1:0] req_hu_second;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [STATUS_BITS-1:0]    rsp_status;
   logic [LABEL_BITS-1:0]     rsp_best_label;
   logic [DIST_BITS-1:0]      rsp_best_distance;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [WEIGHT_BITS-1:0]    csr_write_data;

   shape_item_type            pending_items [$];
   shape_item_type            stored_log [$];
   match_type                 expected_matches [$];
   logic [LABEL_BITS-1:0]     table_labels [TABLE_DEPTH];
   logic [PORT_FEAT_BITS-1:0] table_feats [TABLE_DEPTH][NUM_FEATS];
   int                        table_count;
   logic [WEIGHT_BITS-1:0]    weights [NUM_FEATS];
   int                        send_idle_pct;
   int                        recv_idle_pct;
   int                        error_count;
   int                        quiet_cycles;

   nearest_neighbor_shape_classifier u_top (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [63:0] weighted_square(logic [15:0] a, logic [15:0] b,
                                                   logic [15:0] w);
      logic [15:0] d;
      logic [63:0] p;
      d = (a >= b) ? a - b : b - a;
      p = 64'(d) * 64'(w);
      p = p * p;
      return (p > 64'(DIST_MAX)) ? 64'(DIST_MAX) : p;
   endfunction

   function automatic match_type classify_item(shape_item_type it);
      match_type   m;
      logic [63:0] sum;
      logic [63:0] best;
      m.status = STATUS_MATCH;
      m.label = '0;
      m.distance = '0;
      best = '0;
      if (it.func == FUNC_STORE) begin
         if (table_count >= TABLE_DEPTH) begin
            m.status = STATUS_FULL;
         end else begin
            table_labels[table_count] = it.label;
            for (int f = 0; f < NUM_FEATS; f++) table_feats[table_count][f] = it.feat[f];
            table_count++;
            m.status = STATUS_STORED;
         end
      end else if (table_count == 0) begin
         m.status = STATUS_NO_DATA;
      end else begin
         for (int k = 0; k < table_count; k++) begin
            sum = '0;
            for (int f = 0; f < NUM_FEATS; f++)
               sum += weighted_square(it.feat[f], table_feats[k][f], weights[f]);
            if (sum > 64'(DIST_MAX)) sum = 64'(DIST_MAX);
            if (k == 0 || sum < best) begin
               best = sum;
               m.label = table_labels[k];
            end
         end
         m.distance = best[DIST_BITS-1:0];
      end
      return m;
   endfunction

   function automatic logic [15:0] random_feature();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic shape_item_type random_item(int store_pct);
      shape_item_type it;
      shape_item_type ref_item;
      it.func = ($urandom_range(99) < store_pct) ? FUNC_STORE : FUNC_CLASSIFY;
      it.label = 8'($urandom);
      for (int f = 0; f < NUM_FEATS; f++) it.feat[f] = random_feature();
      if (it.func == FUNC_CLASSIFY && stored_log.size() > 0 && $urandom_range(99) < 60) begin
         ref_item = stored_log[$urandom_range(stored_log.size() - 1)];
         for (int f = 0; f < NUM_FEATS; f++)
            it.feat[f] = ref_item.feat[f] + 16'($urandom_range(8)) - 16'd4;
      end
      return it;
   endfunction

   task automatic add_item(logic func, logic [7:0] label, logic [15:0] f0, logic [15:0] f1,
                           logic [15:0] f2, logic [15:0] f3);
      shape_item_type it;
      it.func = func;
      it.label = label;
      it.feat[0] = f0;
      it.feat[1] = f1;
      it.feat[2] = f2;
      it.feat[3] = f3;
      push_item(it);
   endtask

   task automatic push_item(shape_item_type it);
      pending_items.insert(pending_items.size(), it);
      if (it.func == FUNC_STORE) stored_log.insert(stored_log.size(), it);
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || expected_matches.size() != 0 || req_valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_weight(logic [CSR_INDEX_BITS-1:0] idx, logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      weights[idx] = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic run_random(int count, int store_pct);
      for (int n = 0; n < count; n++) push_item(random_item(store_pct));
   endtask

   // driver
   always @(posedge clock) begin
      shape_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            it = pending_items.pop_front();
            req_valid <= 1'b1;
            req_func <= it.func;
            req_class_label <= it.label;
            req_fill_fraction <= it.feat[0];
            req_aspect_ratio <= it.feat[1];
            req_hu_first <= it.feat[2];
            req_hu_second <= it.feat[3];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor
   always @(posedge clock) begin
      shape_item_type it;
      match_type      want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            it.func = req_func;
            it.label = req_class_label;
            it.feat[0] = req_fill_fraction;
            it.feat[1] = req_aspect_ratio;
            it.feat[2] = req_hu_first;
            it.feat[3] = req_hu_second;
            expected_matches.insert(expected_matches.size(), classify_item(it));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_matches.size() == 0) begin
               report_mismatch("unexpected transfer", 64'(rsp_status), 64'd0);
            end else begin
               want = expected_matches.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_best_label !== want.label)
                  report_mismatch("best_label", 64'(rsp_best_label), 64'(want.label));
               if (rsp_best_distance !== want.distance)
                  report_mismatch("best_distance", 64'(rsp_best_distance),
                                  64'(want.distance));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_STORE;
      req_class_label = '0;
      req_fill_fraction = '0;
      req_aspect_ratio = '0;
      req_hu_first = '0;
      req_hu_second = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_WEIGHT_FILL;
      csr_write_data = '0;
      table_count = 0;
      error_count = 0;
      quiet_cycles = 0;
      weights[CSR_WEIGHT_FILL] = 16'd5;
      weights[CSR_WEIGHT_ASPECT] = 16'd256;
      weights[CSR_WEIGHT_HU_FIRST] = 16'd10;
      weights[CSR_WEIGHT_HU_SECOND] = 16'd100;
      send_idle_pct = 22;
      recv_idle_pct = 79;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, extremes, ties
      add_item(FUNC_CLASSIFY, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_item(FUNC_STORE, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      add_item(FUNC_STORE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_item(FUNC_STORE, 8'h07, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      add_item(FUNC_STORE, 8'hA5, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
      add_item(FUNC_CLASSIFY, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      add_item(FUNC_CLASSIFY, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_item(FUNC_CLASSIFY, 8'h00, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      add_item(FUNC_CLASSIFY, 8'h00, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      add_item(FUNC_STORE, 8'h5A, 16'h8000, 16'h0100, 16'h0001, 16'hFFFE);
      add_item(FUNC_CLASSIFY, 8'h00, 16'h8001, 16'h0100, 16'h0000, 16'hFFFF);
      wait_idle();
      // sender holds off until everything has drained
      run_random(430, 45);
      wait_idle();

      send_idle_pct = 79;
      recv_idle_pct = 22;
      write_weight(CSR_WEIGHT_FILL, 16'hFFFF);
      write_weight(CSR_WEIGHT_ASPECT, 16'hFFFF);
      write_weight(CSR_WEIGHT_HU_FIRST, 16'hFFFF);
      write_weight(CSR_WEIGHT_HU_SECOND, 16'hFFFF);
      add_item(FUNC_CLASSIFY, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_item(FUNC_CLASSIFY, 8'h00, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
      run_random(450, 40);
      wait_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_weight(CSR_WEIGHT_FILL, 16'h0000);
      write_weight(CSR_WEIGHT_ASPECT, 16'($urandom));
      write_weight(CSR_WEIGHT_HU_FIRST, 16'h0001);
      write_weight(CSR_WEIGHT_HU_SECOND, 16'($urandom));
      run_random(250, 40);
      wait_idle();
      for (int f = 0; f < NUM_FEATS; f++) write_weight(f[CSR_INDEX_BITS-1:0], 16'h0000);
      add_item(FUNC_CLASSIFY, 8'h00, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
      add_item(FUNC_STORE, 8'h3C, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
      wait_idle();
      write_weight(CSR_WEIGHT_FILL, 16'($urandom));
      write_weight(CSR_WEIGHT_ASPECT, 16'($urandom));
      write_weight(CSR_WEIGHT_HU_FIRST, 16'($urandom));
      write_weight(CSR_WEIGHT_HU_SECOND, 16'($urandom));
      run_random(250, 30);
      wait_idle();
      repeat (300) @(posedge clock);

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
